[src/class_probability_histogram_defines.svh]
// assertion macros used by the histogram back end
`ifndef CLASS_PROBABILITY_HISTOGRAM_DEFINES_SVH
`define CLASS_PROBABILITY_HISTOGRAM_DEFINES_SVH

// property holds at every edge out of reset
`define CPH_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// trigger implies the consequence in the next cycle
`define CPH_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

[src/cph_pkg.sv]
// shared constants, types and helpers of the class probability histogram
package cph_pkg;

  localparam int BINS        = 8;
  localparam int CLASSES     = 16;
  localparam int EDGE_REGS   = 7;
  localparam int MEM_DEPTH   = CLASSES * BINS;
  localparam int ADDR_W      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int OP_W    = 2;
  localparam int CLS_W   = 4;
  localparam int BIN_W   = 3;
  localparam int PROB_W  = 17;
  localparam int COUNT_W = 32;
  localparam int NCLS_W  = 5;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 17;

  localparam logic [OP_W-1:0] OP_UPDATE = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLASSES = 4'd7;
  localparam logic [NCLS_W-1:0]    NUM_CLASSES_RESET = 5'd16;

  typedef enum logic [1:0] {
    K_NONE,
    K_UPDATE,
    K_CLEAR,
    K_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [BIN_W-1:0]  bin;
    logic              rej;
    logic              hit;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } back_state_t;

  // uniform bin edges after reset
  function automatic logic [PROB_W-1:0] edge_reset(input int k);
    return PROB_W'(((k + 1) * 65536) / BINS);
  endfunction

endpackage

[src/cph_if.sv]
// handshake channels of the class probability histogram
interface cph_in_if;
  logic                      valid;
  logic                      ready;
  logic [cph_pkg::OP_W-1:0]   operation;
  logic [cph_pkg::CLS_W-1:0]  class_index;
  logic [cph_pkg::BIN_W-1:0]  bin_select;
  logic [cph_pkg::PROB_W-1:0] probability;

  modport source (output valid, operation, class_index, bin_select, probability, input ready);
  modport sink   (input valid, operation, class_index, bin_select, probability, output ready);
endinterface

interface cph_out_if;
  logic                        valid;
  logic                        ready;
  logic [cph_pkg::BIN_W-1:0]   bin_index;
  logic [cph_pkg::COUNT_W-1:0] count_value;
  logic                        rejected;

  modport source (output valid, bin_index, count_value, rejected, input ready);
  modport sink   (input valid, bin_index, count_value, rejected, output ready);
endinterface

interface cph_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cph_pkg::CFG_IDX_W-1:0]  index;
  logic [cph_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/class_probability_histogram.sv]
// top level of the class probability histogram
// Per-class histogram of classifier probabilities: an update item bins its Q1.16 probability
// against the edge registers and bumps that class's 32-bit counter, a clear item zeroes all
// counters at once through per-counter valid flags, and a read item returns one counter.
// Every item yields one result item. The front decodes and bins an item in the cycle it is
// accepted and queues it; the back works on one item at a time: it reads the counter memory
// as it pops the item, then increments, writes back and loads the result register once that
// register is free, and only then takes the next item, as the read-modify-write uses the
// single counter memory port. No clearing pass follows reset. Config writes are always ready.
module class_probability_histogram (
  input  logic       clk,
  input  logic       rst_n,
  cph_in_if.sink     in_bus,
  cph_out_if.source  out_bus,
  cph_cfg_if.sink    cfg_bus
);

  cph_pkg::queue_status_t q_status;
  cph_pkg::cmd_t          push_cmd;
  cph_pkg::cmd_t          head;
  logic                   push;
  logic                   pop;

  cph_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .cfg_bus  (cfg_bus),
    .q_status (q_status),
    .push     (push),
    .push_cmd (push_cmd)
  );

  cph_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  cph_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .out_bus  (out_bus)
  );

endmodule

[src/cph_front.sv]
// front end: config registers, item decode, bin search and class check
module cph_front (
  input  logic                   clk,
  input  logic                   rst_n,
  cph_in_if.sink                 in_bus,
  cph_cfg_if.sink                cfg_bus,
  input  cph_pkg::queue_status_t q_status,
  output logic                   push,
  output cph_pkg::cmd_t          push_cmd
);

  logic [cph_pkg::PROB_W-1:0] edge_r [cph_pkg::EDGE_REGS];
  logic [cph_pkg::NCLS_W-1:0] num_classes_r;
  logic [cph_pkg::BIN_W-1:0]  found_bin;
  logic                       cls_rej;
  logic                       cfg_we;

  assign cfg_bus.ready = 1'b1;
  assign cfg_we        = cfg_bus.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < cph_pkg::EDGE_REGS; k++) begin
        edge_r[k] <= cph_pkg::edge_reset(k);
      end
      num_classes_r <= cph_pkg::NUM_CLASSES_RESET;
    end else if (cfg_we) begin
      for (int k = 0; k < cph_pkg::EDGE_REGS; k++) begin
        if (cfg_bus.index == cph_pkg::CFG_IDX_W'(k)) begin
          edge_r[k] <= cfg_bus.data;
        end
      end
      if (cfg_bus.index == cph_pkg::CFG_NUM_CLASSES) begin
        num_classes_r <= cfg_bus.data[cph_pkg::NCLS_W-1:0];
      end
    end
  end

  // first edge strictly above the probability
  always_comb begin
    found_bin = cph_pkg::BIN_W'(cph_pkg::BINS - 1);
    for (int b = cph_pkg::BINS - 2; b >= 0; b--) begin
      if (in_bus.probability < edge_r[b]) begin
        found_bin = cph_pkg::BIN_W'(b);
      end
    end
  end

  assign cls_rej = ({1'b0, in_bus.class_index} >= num_classes_r) ||
                   (32'(in_bus.class_index) >= cph_pkg::CLASSES);

  always_comb begin
    push_cmd.kind = cph_pkg::K_NONE;
    push_cmd.bin  = '0;
    push_cmd.rej  = 1'b0;
    push_cmd.hit  = 1'b0;
    push_cmd.addr = '0;
    case (in_bus.operation)
      cph_pkg::OP_UPDATE: begin
        push_cmd.kind = cph_pkg::K_UPDATE;
        push_cmd.rej  = cls_rej;
        push_cmd.hit  = !cls_rej;
        push_cmd.bin  = cls_rej ? '0 : found_bin;
        push_cmd.addr = cph_pkg::ADDR_W'(32'(in_bus.class_index) * cph_pkg::BINS +
                                         32'(found_bin));
      end
      cph_pkg::OP_CLEAR: begin
        push_cmd.kind = cph_pkg::K_CLEAR;
      end
      cph_pkg::OP_READ: begin
        push_cmd.kind = cph_pkg::K_READ;
        push_cmd.rej  = cls_rej;
        push_cmd.hit  = !cls_rej && (32'(in_bus.bin_select) < cph_pkg::BINS);
        push_cmd.bin  = in_bus.bin_select;
        push_cmd.addr = cph_pkg::ADDR_W'(32'(in_bus.class_index) * cph_pkg::BINS +
                                         32'(in_bus.bin_select));
      end
      default: begin
        push_cmd.kind = cph_pkg::K_NONE;
      end
    endcase
  end

  assign in_bus.ready = !q_status.full;
  assign push         = in_bus.valid && !q_status.full;

endmodule

[src/cph_queue.sv]
// short command queue between front and back
module cph_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  cph_pkg::cmd_t          push_cmd,
  input  logic                   pop,
  output cph_pkg::cmd_t          head,
  output cph_pkg::queue_status_t status
);

  cph_pkg::cmd_t              slot_r [cph_pkg::QUEUE_DEPTH];
  logic [cph_pkg::QPTR_W-1:0] wr_ptr_r;
  logic [cph_pkg::QPTR_W-1:0] rd_ptr_r;
  logic [cph_pkg::QCNT_W-1:0] cnt_r;
  logic [cph_pkg::QPTR_W-1:0] wr_ptr_nxt;
  logic [cph_pkg::QPTR_W-1:0] rd_ptr_nxt;
  logic [cph_pkg::QCNT_W-1:0] cnt_nxt;
  logic                       do_push;
  logic                       do_pop;

  assign status.full  = (cnt_r == cph_pkg::QCNT_W'(cph_pkg::QUEUE_DEPTH));
  assign status.empty = (cnt_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == cph_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == cph_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[src/cph_back.sv]
// back end: counter memory, read-modify-write and result register
`include "class_probability_histogram_defines.svh"

module cph_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cph_pkg::cmd_t          head,
  input  cph_pkg::queue_status_t q_status,
  output logic                   pop,
  cph_out_if.source              out_bus
);

  logic [cph_pkg::COUNT_W-1:0] mem [cph_pkg::MEM_DEPTH];
  logic [cph_pkg::MEM_DEPTH-1:0] valid_r;

  cph_pkg::back_state_t        state_r;
  cph_pkg::back_state_t        state_nxt;
  cph_pkg::cmd_t               cur_r;
  logic [cph_pkg::COUNT_W-1:0] rd_data_r;
  logic                        rd_valid_r;

  logic                        out_valid_r;
  logic [cph_pkg::BIN_W-1:0]   out_bin_r;
  logic [cph_pkg::COUNT_W-1:0] out_count_r;
  logic                        out_rej_r;

  logic                        out_free;
  logic                        go;
  logic                        wr_en;
  logic [cph_pkg::COUNT_W-1:0] base_count;
  logic [cph_pkg::COUNT_W-1:0] res_count;

  assign out_free = !out_valid_r || out_bus.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cph_pkg::S_IDLE: begin
        if (!q_status.empty) state_nxt = cph_pkg::S_EXEC;
      end
      cph_pkg::S_EXEC: begin
        if (out_free) state_nxt = cph_pkg::S_IDLE;
      end
      default: state_nxt = cph_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    pop = 1'b0;
    go  = 1'b0;
    case (state_r)
      cph_pkg::S_IDLE: pop = !q_status.empty;
      cph_pkg::S_EXEC: go  = out_free;
      default: begin
        pop = 1'b0;
        go  = 1'b0;
      end
    endcase
  end

  assign base_count = rd_valid_r ? rd_data_r : '0;
  assign res_count  = cur_r.hit ?
                      base_count + cph_pkg::COUNT_W'(cur_r.kind == cph_pkg::K_UPDATE) : '0;
  assign wr_en      = go && cur_r.hit && (cur_r.kind == cph_pkg::K_UPDATE);

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_data_r <= mem[head.addr];
    end
    if (wr_en) begin
      mem[cur_r.addr] <= res_count;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r      <= head;
      rd_valid_r <= valid_r[head.addr];
    end
    if (go) begin
      out_bin_r   <= cur_r.bin;
      out_count_r <= res_count;
      out_rej_r   <= cur_r.rej;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cph_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
      if (go && cur_r.kind == cph_pkg::K_CLEAR) begin
        valid_r <= '0;
      end else if (wr_en) begin
        valid_r[cur_r.addr] <= 1'b1;
      end
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.bin_index   = out_bin_r;
  assign out_bus.count_value = out_count_r;
  assign out_bus.rejected    = out_rej_r;

  `CPH_ASSERT_NEXT(a_go_loads_result, clk, rst_n, go, out_valid_r, "finished item not presented")
  `CPH_ASSERT_NEXT(a_clear_drops_all, clk, rst_n, go && cur_r.kind == cph_pkg::K_CLEAR, valid_r == '0, "clear left live counters")
  `CPH_ASSERT_ALWAYS(a_rej_zero_count, clk, rst_n, !(out_valid_r && out_rej_r) || out_count_r == '0, "rejected item with nonzero count")

endmodule
